>>> design/hvs_pkg.sv
package hvs_pkg;

  localparam logic [31:0] HASH_SEED  = 32'd5381;
  localparam int unsigned HASH_SHIFT = 5;
  localparam int unsigned PORT_TILE_BITS = 8;

  typedef enum logic {
    OP_TILE  = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_e;

  function automatic logic [31:0] hash_mix(input logic [31:0] h, input logic [31:0] t);
    hash_mix = (h << HASH_SHIFT) + h + t;
  endfunction

endpackage

>>> design/hvs_fifo.sv
module hvs_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign data_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> design/hvs_front.sv
module hvs_front
  import hvs_pkg::*;
#(
  parameter int unsigned KEY_TILES = 16,
  parameter int unsigned BUCKETS   = 1024,
  parameter int unsigned TB        = 8,
  localparam int unsigned BW  = $clog2(BUCKETS),
  localparam int unsigned PW  = $clog2(KEY_TILES + 1),
  localparam int unsigned TIW = (KEY_TILES > 1) ? $clog2(KEY_TILES) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    take_i,
  input  logic                    opcode_i,
  input  logic [TB-1:0]           tile_i,
  input  logic                    last_i,
  output logic                    idle_o,
  output logic                    push_o,
  output logic                    job_clear_o,
  output logic [BW-1:0]           job_slot_o,
  output logic [KEY_TILES*TB-1:0] job_key_o
);

  // The quotient is the hash times the rounded-up reciprocal of the bucket count,
  // shifted right by 32 plus the bucket index width; this is exact for every 32-bit hash.
  localparam logic [63:0] RECIP    = ((64'd1 << (32 + BW)) + 64'(BUCKETS) - 64'd1) /
                                     64'(BUCKETS);
  localparam logic [16:0] RECIP_LO = RECIP[16:0];
  localparam logic [15:0] RECIP_HI = RECIP[32:17];

  typedef enum logic [2:0] {
    F_IDLE,
    F_PAD,
    F_MULA,
    F_MULB,
    F_RED
  } state_e;

  state_e                  state_q;
  logic [31:0]             hash_q, hash_d;
  logic [PW-1:0]           pos_q;
  logic [KEY_TILES*TB-1:0] key_q;
  logic [48:0]             prod_lo, plo_q;
  logic [47:0]             prod_hi;
  logic [65:0]             prod_sum;
  logic [31:0]             quo_q, rem_full;
  logic                    room;

  assign room     = (pos_q < PW'(KEY_TILES));
  assign hash_d   = room ? hash_mix(hash_q, 32'(tile_i)) : hash_q;
  assign prod_lo  = 49'(hash_q) * 49'(RECIP_LO);
  assign prod_hi  = 48'(hash_q) * 48'(RECIP_HI);
  assign prod_sum = 66'(plo_q) + (66'(prod_hi) << 17);
  assign rem_full = hash_q - quo_q * 32'(BUCKETS);

  assign idle_o      = (state_q == F_IDLE);
  assign job_key_o   = key_q;
  assign job_slot_o  = rem_full[BW-1:0];
  assign job_clear_o = (state_q == F_IDLE);
  assign push_o      = (take_i && opcode_e'(opcode_i) == OP_CLEAR) ||
                       (state_q == F_RED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      hash_q  <= HASH_SEED;
      pos_q   <= '0;
      key_q   <= '0;
      plo_q   <= '0;
      quo_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (take_i) begin
            if (opcode_e'(opcode_i) == OP_CLEAR) begin
              hash_q <= HASH_SEED;
              pos_q  <= '0;
              key_q  <= '0;
            end else begin
              hash_q <= hash_d;
              if (room) begin
                key_q[pos_q[TIW-1:0]*TB +: TB] <= tile_i;
                pos_q <= pos_q + PW'(1);
              end
              if (last_i) begin
                if (room && (pos_q + PW'(1)) < PW'(KEY_TILES)) begin
                  state_q <= F_PAD;
                end else begin
                  state_q <= F_MULA;
                end
              end
            end
          end
        end
        F_PAD: begin
          hash_q <= hash_mix(hash_q, 32'd0);
          pos_q  <= pos_q + PW'(1);
          if ((pos_q + PW'(1)) == PW'(KEY_TILES)) begin
            state_q <= F_MULA;
          end
        end
        F_MULA: begin
          plo_q   <= prod_lo;
          state_q <= F_MULB;
        end
        F_MULB: begin
          quo_q   <= 32'(prod_sum >> (32 + BW));
          state_q <= F_RED;
        end
        F_RED: begin
          hash_q  <= HASH_SEED;
          pos_q   <= '0;
          key_q   <= '0;
          state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

>>> design/hvs_back.sv
module hvs_back #(
  parameter int unsigned KEY_TILES  = 16,
  parameter int unsigned BUCKETS    = 1024,
  parameter int unsigned POOL_NODES = 4096,
  parameter int unsigned TB         = 8,
  localparam int unsigned BW  = $clog2(BUCKETS),
  localparam int unsigned LW  = $clog2(POOL_NODES + 1),
  localparam int unsigned NW  = $clog2(POOL_NODES),
  localparam int unsigned KW  = $clog2(POOL_NODES * KEY_TILES),
  localparam int unsigned TIW = (KEY_TILES > 1) ? $clog2(KEY_TILES) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    avail_i,
  input  logic                    job_clear_i,
  input  logic [BW-1:0]           job_slot_i,
  input  logic [KEY_TILES*TB-1:0] job_key_i,
  output logic                    pop_o,
  output logic                    init_o,
  output logic                    done_o,
  output logic                    was_new_o,
  output logic                    pool_full_o
);

  typedef enum logic [3:0] {
    B_INIT,
    B_IDLE,
    B_CLR,
    B_HEAD,
    B_LINK,
    B_NXT,
    B_CRD,
    B_CCHK,
    B_WKEY,
    B_LINKW
  } state_e;

  logic [LW-1:0] bucket_mem [BUCKETS];
  logic [LW-1:0] next_mem   [POOL_NODES];
  logic [TB-1:0] key_mem    [POOL_NODES*KEY_TILES];

  state_e                  state_q;
  logic [BW-1:0]           slot_q, clr_q;
  logic [KEY_TILES*TB-1:0] key_q;
  logic [LW-1:0]           link_q, head_q, used_q;
  logic [KW-1:0]           base_q;
  logic [TIW-1:0]          t_q;
  logic                    done_q, new_q, full_q;

  logic [LW-1:0] head_rd_q, next_rd_q, in_link;
  logic [TB-1:0] key_rd_q;
  logic          bucket_we;
  logic [BW-1:0] bucket_wa;
  logic [LW-1:0] bucket_wd;
  logic [NW-1:0] link_node, in_node;
  logic [KW-1:0] key_addr;
  logic [TB-1:0] job_tile;
  logic          link_end, pool_out, key_hit;

  assign pop_o       = (state_q == B_IDLE) && avail_i;
  assign init_o      = (state_q == B_INIT);
  assign done_o      = done_q;
  assign was_new_o   = new_q;
  assign pool_full_o = full_q;

  assign link_node = NW'(link_q - LW'(1));
  assign in_link   = (state_q == B_LINK) ? head_rd_q : next_rd_q;
  assign in_node   = NW'(in_link - LW'(1));
  assign key_addr  = KW'(base_q + KW'(t_q));
  assign job_tile  = key_q[t_q*TB +: TB];

  assign link_end = ((state_q == B_LINK) || (state_q == B_NXT)) && (in_link == '0);
  assign pool_out = (used_q >= LW'(POOL_NODES));
  assign key_hit  = (state_q == B_CCHK) && (key_rd_q == job_tile) &&
                    (t_q == TIW'(KEY_TILES - 1));

  assign bucket_we = (state_q == B_INIT) || (state_q == B_CLR) || (state_q == B_LINKW);
  assign bucket_wa = (state_q == B_LINKW) ? slot_q : clr_q;
  assign bucket_wd = (state_q == B_LINKW) ? LW'(used_q + LW'(1)) : '0;

  always_ff @(posedge clk_i) begin
    if (bucket_we) begin
      bucket_mem[bucket_wa] <= bucket_wd;
    end
    head_rd_q <= bucket_mem[slot_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_LINKW) begin
      next_mem[used_q[NW-1:0]] <= head_q;
    end
    next_rd_q <= next_mem[link_node];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_WKEY) begin
      key_mem[key_addr] <= job_tile;
    end
    key_rd_q <= key_mem[key_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_INIT;
      clr_q   <= '0;
      used_q  <= '0;
      slot_q  <= '0;
      key_q   <= '0;
      link_q  <= '0;
      head_q  <= '0;
      base_q  <= '0;
      t_q     <= '0;
      done_q  <= 1'b0;
      new_q   <= 1'b0;
      full_q  <= 1'b0;
    end else begin
      done_q <= (link_end && pool_out) || key_hit || (state_q == B_LINKW);
      new_q  <= (state_q == B_LINKW);
      full_q <= link_end && pool_out;
      case (state_q)
        B_INIT, B_CLR: begin
          used_q <= '0;
          if (clr_q == BW'(BUCKETS - 1)) begin
            clr_q   <= '0;
            state_q <= B_IDLE;
          end else begin
            clr_q <= clr_q + BW'(1);
          end
        end
        B_IDLE: begin
          if (avail_i) begin
            slot_q <= job_slot_i;
            key_q  <= job_key_i;
            state_q <= job_clear_i ? B_CLR : B_HEAD;
          end
        end
        B_HEAD: state_q <= B_LINK;
        B_LINK, B_NXT: begin
          link_q <= in_link;
          if (state_q == B_LINK) begin
            head_q <= head_rd_q;
          end
          t_q <= '0;
          if (in_link == '0) begin
            if (pool_out) begin
              state_q <= B_IDLE;
            end else begin
              base_q  <= KW'(KW'(used_q[NW-1:0]) * KW'(KEY_TILES));
              state_q <= B_WKEY;
            end
          end else begin
            base_q  <= KW'(KW'(in_node) * KW'(KEY_TILES));
            state_q <= B_CRD;
          end
        end
        B_CRD: state_q <= B_CCHK;
        B_CCHK: begin
          if (key_rd_q != job_tile) begin
            state_q <= B_NXT;
          end else if (t_q == TIW'(KEY_TILES - 1)) begin
            state_q <= B_IDLE;
          end else begin
            t_q     <= t_q + TIW'(1);
            state_q <= B_CRD;
          end
        end
        B_WKEY: begin
          if (t_q == TIW'(KEY_TILES - 1)) begin
            state_q <= B_LINKW;
          end else begin
            t_q <= t_q + TIW'(1);
          end
        end
        B_LINKW: begin
          used_q  <= used_q + LW'(1);
          state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

>>> design/hashed_visited_set_insert.sv
// Visited-set engine: keys arrive one tile per beat and are hashed with djb2 while they
// are buffered. The last tile starts a pad of the hash for missing tiles and a modulo
// by reciprocal multiplication; the key then moves through a two-entry queue to the
// back end, which walks the bucket chain comparing tile by tile, and inserts by
// writing the key tiles and then linking the new node. The result strobe done_o is
// high for one cycle and cannot be stalled by the receiver. After reset, and after a
// clear beat, the bucket table is swept at one entry per cycle; busy stays high
// during the sweep after reset.
module hashed_visited_set_insert #(
  parameter int unsigned KEY_TILES  = 16,
  parameter int unsigned BUCKETS    = 1024,
  parameter int unsigned POOL_NODES = 4096,
  parameter int unsigned TILE_BITS  = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       opcode_i,
  input  logic [7:0] tile_value_i,
  input  logic       last_tile_i,
  output logic       done_o,
  output logic       was_new_o,
  output logic       pool_full_o
);

  localparam int unsigned TB = (TILE_BITS < 8) ? TILE_BITS : 8;
  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned KB = KEY_TILES * TB;
  localparam int unsigned JW = 1 + BW + KB;

  logic          front_idle, push, pop, q_empty, q_full, init;
  logic          f_clear, b_clear;
  logic [BW-1:0] f_slot, b_slot;
  logic [KB-1:0] f_key, b_key;
  logic [JW-1:0] q_out;

  assign busy = !front_idle || q_full || init;

  hvs_front #(
    .KEY_TILES(KEY_TILES),
    .BUCKETS  (BUCKETS),
    .TB       (TB)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (start && !busy),
    .opcode_i   (opcode_i),
    .tile_i     (tile_value_i[TB-1:0]),
    .last_i     (last_tile_i),
    .idle_o     (front_idle),
    .push_o     (push),
    .job_clear_o(f_clear),
    .job_slot_o (f_slot),
    .job_key_o  (f_key)
  );

  hvs_fifo #(
    .WIDTH(JW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({f_clear, f_slot, f_key}),
    .pop_i  (pop),
    .data_o (q_out),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  assign {b_clear, b_slot, b_key} = q_out;

  hvs_back #(
    .KEY_TILES (KEY_TILES),
    .BUCKETS   (BUCKETS),
    .POOL_NODES(POOL_NODES),
    .TB        (TB)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .avail_i    (!q_empty),
    .job_clear_i(b_clear),
    .job_slot_i (b_slot),
    .job_key_i  (b_key),
    .pop_o      (pop),
    .init_o     (init),
    .done_o     (done_o),
    .was_new_o  (was_new_o),
    .pool_full_o(pool_full_o)
  );

endmodule
